[design/mlbs_pkg.sv]
// ----------------------------------------------------------------------------
// mlbs_pkg: shared types and constants of the multi-LED blink sequencer
// Operation codes, phase encoding, the command broadcast to every LED cell
// and the mask word that travels down the row of cells.
// ----------------------------------------------------------------------------
package mlbs_pkg;

  localparam int OP_W     = 2;
  localparam int LED_W    = 4;
  localparam int COUNT_W  = 16;
  localparam int PERIOD_W = 16;
  localparam int MASK_W   = 4;
  localparam int BLINK_W  = 8;
  localparam int PLEN_W   = 11;

  localparam logic [BLINK_W-1:0]  MAX_BLINKS = 8'd255;
  localparam logic [PLEN_W-1:0]   MAX_PERIOD = 11'd1024;
  localparam logic [PLEN_W-1:0]   MIN_PERIOD = 11'd4;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_BLINK = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } phase_t;

  // Command seen by every cell in the cycle of an input transfer
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [LED_W-1:0]    led;
    logic [COUNT_W-1:0]  count;
    logic [PLEN_W-1:0]   plen;
  } cmd_t;

  // Masks gathered along the row of cells
  typedef struct packed {
    logic [MASK_W-1:0] lamp;
    logic [MASK_W-1:0] busy;
  } mask_t;

endpackage

[design/mlbs_cell.sv]
// ----------------------------------------------------------------------------
// mlbs_cell: one LED of the blink sequencer
// Holds the blink count, period, phase and countdown of one LED, applies the
// broadcast command and adds its lamp and busy bits to the passing masks.
// ----------------------------------------------------------------------------
module mlbs_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mlbs_pkg::cmd_t                   cmd,
  input  mlbs_pkg::mask_t                  mask_in,
  output mlbs_pkg::mask_t                  mask_out
);

  logic [mlbs_pkg::BLINK_W-1:0] blinks_r, blinks_nxt;
  logic [mlbs_pkg::PLEN_W-1:0]  plen_r, plen_nxt;
  mlbs_pkg::phase_t             phase_r, phase_nxt;
  logic [mlbs_pkg::PLEN_W-1:0]  cd_r, cd_nxt;
  logic                         lit_r, lit_nxt;

  logic                          hit;
  logic [mlbs_pkg::PLEN_W-1:0]   cd_dec;
  logic [mlbs_pkg::BLINK_W-1:0]  blinks_dec;
  logic [mlbs_pkg::COUNT_W:0]    blinks_sum;

  assign hit        = (cmd.led == mlbs_pkg::LED_W'(IDX));
  assign cd_dec     = (cd_r != '0) ? cd_r - 1'b1 : '0;
  assign blinks_dec = (blinks_r != '0) ? blinks_r - 1'b1 : '0;
  assign blinks_sum = {{(mlbs_pkg::COUNT_W + 1 - mlbs_pkg::BLINK_W){1'b0}}, blinks_r}
                    + {1'b0, cmd.count};

  // Next state of this LED
  always_comb begin
    blinks_nxt = blinks_r;
    plen_nxt   = plen_r;
    phase_nxt  = phase_r;
    cd_nxt     = cd_r;
    lit_nxt    = lit_r;
    if (cmd.valid) begin
      case (cmd.op)
        mlbs_pkg::OP_TICK: begin
          if (phase_r != mlbs_pkg::PH_IDLE) begin
            cd_nxt = cd_dec;
            if (cd_dec == '0) begin
              if (phase_r == mlbs_pkg::PH_ON) begin
                lit_nxt   = 1'b0;
                phase_nxt = mlbs_pkg::PH_OFF;
                cd_nxt    = plen_r;
              end else begin
                blinks_nxt = blinks_dec;
                if (blinks_dec != '0) begin
                  lit_nxt   = 1'b1;
                  phase_nxt = mlbs_pkg::PH_ON;
                  cd_nxt    = plen_r;
                end else begin
                  lit_nxt   = 1'b0;
                  phase_nxt = mlbs_pkg::PH_IDLE;
                  cd_nxt    = '0;
                end
              end
            end
          end
        end
        mlbs_pkg::OP_BLINK: begin
          if (hit) begin
            if (cmd.count == '0) begin
              // let the current blink finish
              if (blinks_r > mlbs_pkg::BLINK_W'(1)) begin
                blinks_nxt = mlbs_pkg::BLINK_W'(1);
              end
            end else begin
              blinks_nxt = (blinks_sum > {{(mlbs_pkg::COUNT_W + 1 - mlbs_pkg::BLINK_W){1'b0}},
                                          mlbs_pkg::MAX_BLINKS})
                         ? mlbs_pkg::MAX_BLINKS : blinks_sum[mlbs_pkg::BLINK_W-1:0];
              plen_nxt   = cmd.plen;
              if (blinks_r == '0) begin
                lit_nxt   = 1'b1;
                phase_nxt = mlbs_pkg::PH_ON;
                cd_nxt    = cmd.plen;
              end
            end
          end
        end
        mlbs_pkg::OP_STOP: begin
          blinks_nxt = '0;
          plen_nxt   = '0;
          phase_nxt  = mlbs_pkg::PH_IDLE;
          cd_nxt     = '0;
          lit_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blinks_r <= '0;
      plen_r   <= '0;
      phase_r  <= mlbs_pkg::PH_IDLE;
      cd_r     <= '0;
      lit_r    <= 1'b0;
    end else begin
      blinks_r <= blinks_nxt;
      plen_r   <= plen_nxt;
      phase_r  <= phase_nxt;
      cd_r     <= cd_nxt;
      lit_r    <= lit_nxt;
    end
  end

  // Add this LED's bits (state after the step) to the passing masks; cells beyond the mask width add none
  generate
    if (IDX < mlbs_pkg::MASK_W) begin : g_visible
      always_comb begin
        mask_out           = mask_in;
        mask_out.lamp[IDX] = lit_nxt;
        mask_out.busy[IDX] = (phase_nxt != mlbs_pkg::PH_IDLE);
      end
    end else begin : g_hidden
      assign mask_out = mask_in;
    end
  endgenerate

  a_lit_only_on: assert property (@(posedge clk) disable iff (!rst_n)
    lit_r |-> (phase_r == mlbs_pkg::PH_ON))
    else $error("LED lit outside its on phase");

  a_idle_no_blinks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mlbs_pkg::PH_IDLE) == (blinks_r == '0))
    else $error("idle phase and blink count disagree");

  a_running_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != mlbs_pkg::PH_IDLE) |-> (cd_r != '0))
    else $error("running LED with an empty countdown");

endmodule

[design/multi_led_blink_sequencer.sv]
// ----------------------------------------------------------------------------
// multi_led_blink_sequencer: row of per-LED blink cells
// Broadcasts ticks, blink requests and stop-all to a row of LED cells and
// reports which LEDs are lit and which are running after every transfer.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | operation, led, count, period
//   out_    | output    | out_valid/out_stall| lamp_mask, busy_mask
//
// One item per cycle while in_stall is low: every cell updates its state in the cycle
// of the input transfer, and the masks ripple down the row into the output register
// or, while the output register is full and out_stall is high, into the skid register.
// A skid register takes one more result while out_stall is high; in_stall
// rises only while that skid register is full.
// Reset (rst_n low, synchronous) clears every LED and empties both registers.
// ----------------------------------------------------------------------------
module multi_led_blink_sequencer #(
  parameter int LED_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mlbs_pkg::OP_W-1:0]      in_operation,
  input  logic [mlbs_pkg::LED_W-1:0]     in_led,
  input  logic [mlbs_pkg::COUNT_W-1:0]   in_count,
  input  logic [mlbs_pkg::PERIOD_W-1:0]  in_period,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mlbs_pkg::MASK_W-1:0]    out_lamp_mask,
  output logic [mlbs_pkg::MASK_W-1:0]    out_busy_mask
);

  logic            in_fire;
  logic            out_fire;
  mlbs_pkg::cmd_t  cmd;
  mlbs_pkg::mask_t mask_chain [LED_COUNT+1];
  mlbs_pkg::mask_t mask_new;

  logic            out_valid_r, out_valid_nxt;
  mlbs_pkg::mask_t out_mask_r, out_mask_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  mlbs_pkg::mask_t skid_mask_r, skid_mask_nxt;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  // Decode the command and clamp the period once for all cells
  always_comb begin
    cmd.valid = in_fire;
    cmd.op    = mlbs_pkg::op_t'(in_operation);
    cmd.led   = in_led;
    cmd.count = in_count;
    if (in_period > mlbs_pkg::PERIOD_W'(mlbs_pkg::MAX_PERIOD)) begin
      cmd.plen = mlbs_pkg::MAX_PERIOD;
    end else if (in_period < mlbs_pkg::PERIOD_W'(mlbs_pkg::MIN_PERIOD)) begin
      cmd.plen = mlbs_pkg::MIN_PERIOD;
    end else begin
      cmd.plen = in_period[mlbs_pkg::PLEN_W-1:0];
    end
  end

  // Row of LED cells
  assign mask_chain[0] = '0;
  generate
    for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
      mlbs_cell #(.IDX(i)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .mask_in  (mask_chain[i]),
        .mask_out (mask_chain[i+1])
      );
    end
  endgenerate
  assign mask_new = mask_chain[LED_COUNT];

  // Output register with skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_mask_nxt   = out_mask_r;
    skid_valid_nxt = skid_valid_r;
    skid_mask_nxt  = skid_mask_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_mask_nxt   = skid_mask_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_fire) begin
        skid_mask_nxt  = mask_new;
        skid_valid_nxt = 1'b1;
      end else begin
        out_mask_nxt  = mask_new;
        out_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r  <= out_mask_nxt;
    skid_mask_r <= skid_mask_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_lamp_mask = out_mask_r.lamp;
  assign out_busy_mask = out_mask_r.busy;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_transfer_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("input transfer produced no result");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (!skid_valid_r && out_valid_r))
    else $error("skid register did not move to the output");

endmodule
